/* rtl/rgb_color_calibrate_classify_macros.svh */
// Assertion macros for the colour calibrate/classify block.
// Both macros assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef RGB_COLOR_CALIBRATE_CLASSIFY_MACROS_SVH
`define RGB_COLOR_CALIBRATE_CLASSIFY_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccc assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define CCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccc assertion failed");

`endif

/* rtl/ccc_pkg.sv */
// Package for the colour calibrate/classify block: widths, codes, control types
// and the colour decision function. No dependencies.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int unsigned TABLE_ROWS = 3;
  localparam int unsigned TABLE_COLS = 4;
  localparam int unsigned TABLE_SIZE = TABLE_ROWS * TABLE_COLS;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
  localparam int unsigned ROW_W      = $clog2(TABLE_ROWS);
  localparam int unsigned COL_W      = $clog2(TABLE_COLS);

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned GAIN_W     = 32;

  localparam int unsigned ADC_W  = 10;
  localparam int unsigned SCL_W  = 11;
  localparam int unsigned CAL_W  = 16;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned MINA_W = 11;
  localparam int unsigned ADIV_W = 10;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 22;
  localparam int unsigned MUL_B_W = GAIN_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // x*50/33 as x * (50 * ceil(2^21/33)) >> 21, exact for 10-bit x
  localparam logic [MUL_A_W-1:0] SCALE_MUL = 22'd3177550;
  localparam int unsigned SCALE_SHIFT = 21;
  localparam int unsigned CAL_SHIFT   = 16;
  localparam logic [17:0] AMB_GAIN    = 18'd100;

  // Divider: 18-bit dividend, 10-bit divisor, two quotient bits per cycle
  localparam int unsigned DIVD_W        = 18;
  localparam int unsigned DIVS_W        = ADIV_W;
  localparam int unsigned DIV_BITS_STEP = 2;
  localparam int unsigned DIV_ITERS     = DIVD_W / DIV_BITS_STEP;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_ITERS);

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [COL_W-1:0] COL_AMB = 2'd3;

  typedef enum logic [1:0] {
    REG_LIMIT_UPPER = 2'd0,
    REG_LIMIT_LOWER = 2'd1,
    REG_MIN_AMBIENT = 2'd2,
    REG_AMB_DIVISOR = 2'd3
  } reg_e;

  typedef enum logic [CODE_W-1:0] {
    CODE_BLACK  = 3'd0,
    CODE_BLUE   = 3'd1,
    CODE_GREEN  = 3'd2,
    CODE_YELLOW = 3'd3,
    CODE_RED    = 3'd4,
    CODE_WHITE  = 3'd5
  } color_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_AMB,
    ST_LAST,
    ST_PUSH
  } seq_state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RAW,
    SRC_DIFF,
    SRC_QUOT
  } mul_src_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_AMB,
    WB_RED,
    WB_GREEN,
    WB_BLUE,
    WB_CAL_R,
    WB_CAL_G,
    WB_CAL_B,
    WB_CAL_A
  } wb_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    mul_src_e src;
    wb_e      tag;
    logic     div_start;
    logic     push;
  } seq_ctrl_t;

  // Decision thresholds
  localparam logic [CAL_W-1:0] TH_R_MIN     = 16'd65;
  localparam logic [CAL_W-1:0] TH_R_AMB     = 16'd40;
  localparam logic [CAL_W-1:0] TH_R_DIM     = 16'd110;
  localparam logic [CAL_W-1:0] TH_WHITE_MIN = 16'd70;
  localparam logic [CAL_W-1:0] TH_WHITE_AMB = 16'd140;
  localparam logic [CAL_W-1:0] TH_G_MIN     = 16'd40;
  localparam logic [CAL_W-1:0] TH_G_AMB     = 16'd30;
  localparam logic [CAL_W-1:0] TH_G_DIM     = 16'd70;
  localparam logic [CAL_W-1:0] TH_B_MIN     = 16'd48;
  localparam logic [CAL_W-1:0] TH_B_AMB     = 16'd25;
  localparam logic [CAL_W-1:0] TH_B_DIM     = 16'd85;
  localparam logic [CAL_W-1:0] TH_BW_MIN    = 16'd60;
  localparam logic [CAL_W-1:0] TH_BW_AMB    = 16'd110;
  localparam logic [CAL_W-1:0] TH_BW_DIM    = 16'd120;
  localparam logic [21:0]      BLUE_MUL_LO  = 22'd48;
  localparam logic [21:0]      BLUE_MUL_HI  = 22'd58;

  function automatic color_e classify_color(input logic [CAL_W-1:0] r,
                                            input logic [CAL_W-1:0] g,
                                            input logic [CAL_W-1:0] b,
                                            input logic [CAL_W-1:0] a);
    logic [17:0] b_mix, g_dbl, g_red, r_125, b_125, b_dbl, r_1125, g_1125;
    logic [21:0] r48, g48, r58, g58;
    color_e      code;
    b_mix  = {2'b0, b} + {4'b0, b[15:2]} + {5'b0, b[15:3]};
    g_dbl  = {1'b0, g, 1'b0};
    g_red  = g_dbl - {4'b0, g[15:2]};
    r_125  = {2'b0, r} + {4'b0, r[15:2]};
    b_125  = {2'b0, b} + {4'b0, b[15:2]};
    b_dbl  = {1'b0, b, 1'b0};
    r_1125 = {2'b0, r} + {5'b0, r[15:3]};
    g_1125 = {2'b0, g} + {5'b0, g[15:3]};
    r48    = ({6'b0, r} * BLUE_MUL_LO) >> 5;
    g48    = ({6'b0, g} * BLUE_MUL_LO) >> 5;
    r58    = ({6'b0, r} * BLUE_MUL_HI) >> 5;
    g58    = ({6'b0, g} * BLUE_MUL_HI) >> 5;
    if (r > b && r > g) begin
      if (r < TH_R_MIN || (a < TH_R_AMB && r < TH_R_DIM)) code = CODE_BLACK;
      else if (b_mix < {2'b0, g} && g_dbl > {2'b0, r}) code = CODE_YELLOW;
      else if (g_red < {2'b0, r}) code = CODE_RED;
      else if (b < TH_WHITE_MIN || g < TH_WHITE_MIN ||
               (a < TH_WHITE_AMB && r < TH_WHITE_AMB)) code = CODE_BLACK;
      else code = CODE_WHITE;
    end else if (g > b) begin
      if (g < TH_G_MIN || (a < TH_G_AMB && g < TH_G_DIM)) code = CODE_BLACK;
      else if (b_dbl < {2'b0, r}) code = CODE_YELLOW;
      else if (r_125 < {2'b0, g} || b_125 < {2'b0, g}) code = CODE_GREEN;
      else if (r < TH_WHITE_MIN || b < TH_WHITE_MIN ||
               (a < TH_WHITE_AMB && g < TH_WHITE_AMB)) code = CODE_BLACK;
      else code = CODE_WHITE;
    end else begin
      if (b < TH_B_MIN || (a < TH_B_AMB && b < TH_B_DIM)) code = CODE_BLACK;
      else if ((r48 < {6'b0, b} && g48 < {6'b0, b}) ||
               r58 < {6'b0, b} || g58 < {6'b0, b}) code = CODE_BLUE;
      else if (r < TH_BW_MIN || g < TH_BW_MIN ||
               (a < TH_BW_AMB && b < TH_BW_DIM)) code = CODE_BLACK;
      else if (r_1125 < {2'b0, b} || g_1125 < {2'b0, b}) code = CODE_BLUE;
      else code = CODE_WHITE;
    end
    return code;
  endfunction

endpackage

/* rtl/rgb_color_calibrate_classify.sv */
// RGB colour sensor calibration and classification. A load beat (operation 0)
// writes one 32-bit gain word into the 3x4 table and yields no
// result; the table holds no reset value, so load every word of a row before
// classifying with it. A classify beat (operation 1) takes four 10-bit ADC
// readings and yields one result beat; the input stalls from then until that
// result is pushed, so a new beat is not taken while one is still in progress.
// The sequence is the shared multiplier's four scale products and three colour
// gain products, with the radix-4 ambient divider overlapping the colour
// products, followed by the ambient gain product.
// A result waiting in the output register does not block a new input beat.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12; write them
// only while the block is idle. Depends on ccc_pkg and ccc_div.
`timescale 1ns / 1ps

module rgb_color_calibrate_classify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ccc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ccc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ccc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [ccc_pkg::SLOT_W-1:0]     table_slot_i,
  input  logic [ccc_pkg::GAIN_W-1:0]     table_word_i,
  input  logic [ccc_pkg::ADC_W-1:0]      ambient_adc_i,
  input  logic [ccc_pkg::ADC_W-1:0]      red_adc_i,
  input  logic [ccc_pkg::ADC_W-1:0]      green_adc_i,
  input  logic [ccc_pkg::ADC_W-1:0]      blue_adc_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ccc_pkg::CODE_W-1:0]     color_code_o,
  output logic [ccc_pkg::CAL_W-1:0]      cal_red_o,
  output logic [ccc_pkg::CAL_W-1:0]      cal_green_o,
  output logic [ccc_pkg::CAL_W-1:0]      cal_blue_o,
  output logic [ccc_pkg::CAL_W-1:0]      cal_ambient_o
);
  import ccc_pkg::*;

  // Steps of the multiplier sequence inside ST_RUN
  localparam logic [2:0] STEP_SCL_AMB = 3'd0;
  localparam logic [2:0] STEP_SCL_R   = 3'd1;
  localparam logic [2:0] STEP_SCL_G   = 3'd2;
  localparam logic [2:0] STEP_SCL_B   = 3'd3;
  localparam logic [2:0] STEP_CAL_R   = 3'd4;
  localparam logic [2:0] STEP_CAL_G   = 3'd5;
  localparam logic [2:0] STEP_CAL_B   = 3'd6;
  localparam logic [2:0] STEP_DRAIN   = 3'd7;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CAL_W-1:0]  limit_upper_q, limit_lower_q;
  logic [MINA_W-1:0] min_ambient_q;
  logic [ADIV_W-1:0] ambient_divisor_q;
  logic              cfg_we;
  reg_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_upper_q     <= '0;
      limit_lower_q     <= '0;
      min_ambient_q     <= MINA_W'(214);
      ambient_divisor_q <= ADIV_W'(79);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LIMIT_UPPER: limit_upper_q     <= pwdata[CAL_W-1:0];
        REG_LIMIT_LOWER: limit_lower_q     <= pwdata[CAL_W-1:0];
        REG_MIN_AMBIENT: min_ambient_q     <= pwdata[MINA_W-1:0];
        REG_AMB_DIVISOR: ambient_divisor_q <= pwdata[ADIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIMIT_UPPER: prdata = {{(APB_DATA_W-CAL_W){1'b0}}, limit_upper_q};
      REG_LIMIT_LOWER: prdata = {{(APB_DATA_W-CAL_W){1'b0}}, limit_lower_q};
      REG_MIN_AMBIENT: prdata = {{(APB_DATA_W-MINA_W){1'b0}}, min_ambient_q};
      REG_AMB_DIVISOR: prdata = {{(APB_DATA_W-ADIV_W){1'b0}}, ambient_divisor_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  seq_state_e state_q, state_d;
  logic [2:0] st_q, st_d;
  seq_ctrl_t  ctrl;
  div_stat_t  div_stat;
  logic       in_acc;
  logic       out_valid_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    st_d    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == OP_CLASSIFY) state_d = ST_RUN;
      end
      ST_RUN: begin
        st_d = st_q + 1'b1;
        if (st_q == STEP_DRAIN) state_d = ST_AMB;
      end
      ST_AMB: begin
        if (div_stat.done) state_d = ST_LAST;
      end
      ST_LAST: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Each multiply carries a tag that names the register its product lands in
  always_comb begin
    ctrl = '{src: SRC_NONE, tag: WB_NONE, div_start: 1'b0, push: 1'b0};
    case (state_q)
      ST_RUN: begin
        case (st_q)
          STEP_SCL_AMB: ctrl.tag = WB_AMB;
          STEP_SCL_R:   ctrl.tag = WB_RED;
          STEP_SCL_G:   ctrl.tag = WB_GREEN;
          STEP_SCL_B:   ctrl.tag = WB_BLUE;
          STEP_CAL_R:   ctrl.tag = WB_CAL_R;
          STEP_CAL_G:   ctrl.tag = WB_CAL_G;
          STEP_CAL_B:   ctrl.tag = WB_CAL_B;
          default:      ctrl.tag = WB_NONE;
        endcase
        if (st_q <= STEP_SCL_B) ctrl.src = SRC_RAW;
        else if (st_q != STEP_DRAIN) ctrl.src = SRC_DIFF;
        // scaled ambient lands at the end of the red step
        ctrl.div_start = (st_q == STEP_SCL_G);
      end
      ST_AMB: begin
        if (div_stat.done && !div_stat.busy) begin
          ctrl.src = SRC_QUOT;
          ctrl.tag = WB_CAL_A;
        end
      end
      ST_PUSH: ctrl.push = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Gain table and captured readings
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_q [TABLE_SIZE];
  logic [ADC_W-1:0]  raw_q  [4];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (operation_i == OP_LOAD) begin
        // drop loads aimed past the end of the table
        if (32'(table_slot_i) < TABLE_SIZE) gain_q[table_slot_i] <= table_word_i;
      end else begin
        raw_q[0] <= ambient_adc_i;
        raw_q[1] <= red_adc_i;
        raw_q[2] <= green_adc_i;
        raw_q[3] <= blue_adc_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic [SCL_W-1:0]   amb_s_q;
  logic [SCL_W-1:0]   col_s_q [3];
  logic [CAL_W-1:0]   cal_q   [3];
  logic [CAL_W-1:0]   cal_amb_q;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   gcol;
  logic [SCL_W-1:0]   col_sel, diff;
  logic [MINA_W-1:0]  amb_off;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q;
  wb_e                tag_q;
  logic [CAL_W-1:0]   prod_sat;
  logic [DIVD_W-1:0]  quot;
  div_req_t           div_req;

  // Row from scaled ambient; lower limit takes priority
  always_comb begin
    if ({5'b0, amb_s_q} < limit_lower_q)      row = ROW_W'(2);
    else if ({5'b0, amb_s_q} < limit_upper_q) row = ROW_W'(1);
    else                                      row = ROW_W'(0);
  end

  always_comb begin
    case (st_q[1:0])
      2'd0:    col_sel = col_s_q[0];
      2'd1:    col_sel = col_s_q[1];
      default: col_sel = col_s_q[2];
    endcase
  end

  // Clamp colour at ambient so a dim channel multiplies out to zero
  assign diff    = (col_sel > amb_s_q) ? col_sel - amb_s_q : '0;
  assign gcol    = (ctrl.src == SRC_QUOT) ? COL_AMB : st_q[COL_W-1:0];
  assign amb_off = (amb_s_q > min_ambient_q) ? amb_s_q - min_ambient_q : '0;

  always_comb begin
    case (ctrl.src)
      SRC_RAW: begin
        mul_a = {{(MUL_A_W-ADC_W){1'b0}}, raw_q[st_q[1:0]]};
        mul_b = {{(MUL_B_W-MUL_A_W){1'b0}}, SCALE_MUL};
      end
      SRC_DIFF: begin
        mul_a = {{(MUL_A_W-SCL_W){1'b0}}, diff};
        mul_b = gain_q[{row, gcol}];
      end
      SRC_QUOT: begin
        mul_a = {{(MUL_A_W-DIVD_W){1'b0}}, quot};
        mul_b = gain_q[{row, gcol}];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The shared multiplier: one product per cycle, registered with its tag
  always_ff @(posedge clk_i) begin
    prod_q <= {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_q <= WB_NONE;
    else         tag_q <= ctrl.tag;
  end

  // Saturate the product after the 16-bit shift
  assign prod_sat = (prod_q[PROD_W-1:CAL_SHIFT+CAL_W] != '0) ? '1
                                                             : prod_q[CAL_SHIFT +: CAL_W];

  always_ff @(posedge clk_i) begin
    case (tag_q)
      WB_AMB:   amb_s_q    <= prod_q[SCALE_SHIFT +: SCL_W];
      WB_RED:   col_s_q[0] <= prod_q[SCALE_SHIFT +: SCL_W];
      WB_GREEN: col_s_q[1] <= prod_q[SCALE_SHIFT +: SCL_W];
      WB_BLUE:  col_s_q[2] <= prod_q[SCALE_SHIFT +: SCL_W];
      WB_CAL_R: cal_q[0]   <= prod_sat;
      WB_CAL_G: cal_q[1]   <= prod_sat;
      WB_CAL_B: cal_q[2]   <= prod_sat;
      WB_CAL_A: cal_amb_q  <= prod_sat;
      default: ;
    endcase
  end

  // Ambient path: offset ambient times one hundred over the divisor
  assign div_req.start    = ctrl.div_start;
  assign div_req.dividend = {{(DIVD_W-MINA_W){1'b0}}, amb_off} * AMB_GAIN;
  assign div_req.divisor  = ambient_divisor_q;

  ccc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, load on push
  // ---------------------------------------------------------------------------
  color_e           code_q;
  logic [CAL_W-1:0] out_r_q, out_g_q, out_b_q, out_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         out_valid_q <= 1'b0;
    else if (ctrl.push)  out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.push) begin
      code_q  <= classify_color(cal_q[0], cal_q[1], cal_q[2], cal_amb_q);
      out_r_q <= cal_q[0];
      out_g_q <= cal_q[1];
      out_b_q <= cal_q[2];
      out_a_q <= cal_amb_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_code_o  = code_q;
  assign cal_red_o     = out_r_q;
  assign cal_green_o   = out_g_q;
  assign cal_blue_o    = out_b_q;
  assign cal_ambient_o = out_a_q;

endmodule

/* rtl/ccc_div.sv */
// Iterative restoring divider, two quotient bits per cycle.
// Depends on ccc_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module ccc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ccc_pkg::div_req_t          req_i,
  output ccc_pkg::div_stat_t         stat_o,
  output logic [ccc_pkg::DIVD_W-1:0] quot_o
);
  import ccc_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0]    work_q, work_d;
  logic [DIVS_W:0]      rem_q, rem_d;
  logic [DIVS_W-1:0]    dsr_q;
  logic [DIVS_W:0]      trial;

  // Two dependent shift/compare/subtract steps
  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    trial  = '0;
    for (int i = 0; i < DIV_BITS_STEP; i++) begin
      trial = {rem_d[DIVS_W-1:0], work_d[DIVD_W-1]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        work_d = {work_d[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        work_d = {work_d[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= (req_i.divisor == '0) ? DIVS_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = work_q;

endmodule

/* rtl/ccc_checker.sv */
// Port-level checker for rgb_color_calibrate_classify, bound to the top level.
// Depends on ccc_pkg and rgb_color_calibrate_classify_macros.svh.
`timescale 1ns / 1ps
`include "rgb_color_calibrate_classify_macros.svh"

module ccc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  color_code_o,
  input logic [15:0] cal_red_o,
  input logic [15:0] cal_green_o,
  input logic [15:0] cal_blue_o,
  input logic [15:0] cal_ambient_o
);
  import ccc_pkg::*;

  logic        in_beat;
  logic        out_held;
  logic        out_dark;
  logic [66:0] out_pay;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_dark = out_valid_o && (cal_red_o == 16'd0) && (cal_green_o == 16'd0) &&
                    (cal_blue_o == 16'd0);
  assign out_pay  = {color_code_o, cal_red_o, cal_green_o, cal_blue_o, cal_ambient_o};

  // Stalled result beat holds
  `CCC_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_pay))

  // A classify beat keeps the block busy on the next cycle
  `CCC_ASSERT_NEXT(a_classify_busy, in_beat && operation_i == OP_CLASSIFY, in_stall_o)

  // A load beat leaves the input unstalled on the next cycle
  `CCC_ASSERT_NEXT(a_load_quick, in_beat && operation_i == OP_LOAD, !in_stall_o)

  // No colour signal at all must read as black
  `CCC_ASSERT_NOW(a_dark_black, out_dark, color_code_o == CODE_BLACK)

endmodule

bind rgb_color_calibrate_classify ccc_checker u_ccc_checker (.*);
